/* design/rpa_pkg.sv */
// Shared types, codes and defaults for the reference-counted page allocator.
`default_nettype none
package rpa_pkg;

  localparam int ADDR_W = 56;
  localparam int REF_W  = 16;
  localparam int STS_W  = 3;
  localparam int CMD_W  = 2;

  localparam int NUM_PAGES_DEF   = 16384;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [ADDR_W-1:0] REGION_START_RST = 56'd2147483648;
  localparam logic [ADDR_W-1:0] REGION_END_RST   = 56'd2214592512;

  // Configuration register indexes
  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_END   = 1'b1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] ST_ALLOC = 3'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STS_W-1:0] ST_ADDED = 3'd2;
  localparam logic [STS_W-1:0] ST_HELD  = 3'd3;
  localparam logic [STS_W-1:0] ST_FREED = 3'd4;
  localparam logic [STS_W-1:0] ST_BAD   = 3'd5;
  localparam logic [STS_W-1:0] ST_OVER  = 3'd6;

  typedef struct packed {
    logic clear;     // clearing pass: zero one count entry
    logic capture;   // take the input item
    logic check;     // decode command, validate address
    logic issue;     // first memory read
    logic stk;       // stack data back, read its count
    logic update;    // count read-modify-write, push
    logic load_out;  // move result into output register
  } rpa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic early;     // result already known after check
    logic is_alloc;
  } rpa_sts_t;

endpackage
`default_nettype wire

/* design/refcounted_page_allocator.sv */
// Top level of the reference-counted page frame allocator.
// Allocates page frames from a LIFO free stack and keeps a saturating reference count per
// frame; the stack is filled by free commands. After reset the block clears every entry of
// the count memory, stalling input meanwhile (configuration writes are taken at any time).
// Add-reference and free items read the frame's count and write it back; allocation does
// a synchronous read of the stack top, then a dependent read of that frame's count, then
// the count write-back. Rejected and empty-stack items skip the memory accesses.
// Results sit in an output register, so the next item is accepted while one waits; a result
// is held back only when the previous one has not yet been taken.
`default_nettype none
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES   = NUM_PAGES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ADDR_W-1:0] page_addr,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      result_addr,
  output logic [REF_W-1:0]       ref_count,
  output logic [STS_W-1:0]       status
);

  rpa_cmd_t cmd;
  rpa_sts_t sts;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpa_dp #(
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_BYTES  (PAGE_BYTES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .page_addr   (page_addr),
    .result_addr (result_addr),
    .ref_count   (ref_count),
    .status      (status),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
`default_nettype wire

/* design/rpa_ctrl.sv */
// Controller state machine for the page allocator.
`default_nettype none
module rpa_ctrl
  import rpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire rpa_sts_t sts,
  output rpa_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_STK   = 3'd4;
  localparam logic [2:0] S_CNT   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (sts.early) begin
          state_next = S_DONE;
        end else begin
          cmd.issue  = 1'b1;
          state_next = sts.is_alloc ? S_STK : S_CNT;
        end
      end
      S_STK: begin
        cmd.stk    = 1'b1;
        state_next = S_CNT;
      end
      S_CNT: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = (out_valid && out_stall) || cmd.load_out;
  assign in_stall       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

/* design/rpa_dp.sv */
// Datapath for the page allocator: config, address check, free stack and count memories.
`default_nettype none
module rpa_dp
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES   = NUM_PAGES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ADDR_W-1:0] page_addr,
  output logic [ADDR_W-1:0]      result_addr,
  output logic [REF_W-1:0]       ref_count,
  output logic [STS_W-1:0]       status,
  input  wire rpa_cmd_t          cmd,
  output rpa_sts_t               sts
);

  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int PG_SH   = $clog2(PAGE_BYTES);
  localparam int FRM_W   = ADDR_W - PG_SH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [IDX_W-1:0]       stk_mem [NUM_PAGES];
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_PAGES];

  logic [ADDR_W-1:0]      region_start;
  logic [ADDR_W-1:0]      region_end;
  logic [CMD_W-1:0]       cmd_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   early_q;
  logic [DEPTH_W-1:0]     depth;
  logic [IDX_W-1:0]       clr_addr;
  logic [IDX_W-1:0]       stk_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [ADDR_W-1:0]      res_addr;
  logic [REF_W-1:0]       res_count;
  logic [STS_W-1:0]       res_status;

  logic                   addr_ok;
  logic [FRM_W-1:0]       rel;
  logic [FRM_W-1:0]       frame_sum;
  logic                   is_alloc;
  logic                   stk_re;
  logic                   cnt_re;
  logic [IDX_W-1:0]       cnt_ra;
  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   push;
  logic                   stk_full;

  assign is_alloc = (cmd_q == CMD_ALLOC);
  assign stk_full = (depth >= DEPTH_W'(NUM_PAGES));

  // Frame index relative to the region base; nonnegative once addr >= region_start
  assign rel     = addr_q[ADDR_W-1:PG_SH] - region_start[ADDR_W-1:PG_SH];
  assign addr_ok = (addr_q[PG_SH-1:0] == '0) &&
                   (addr_q >= region_start) && (addr_q < region_end) &&
                   (rel < FRM_W'(NUM_PAGES));

  assign frame_sum = region_start[ADDR_W-1:PG_SH] + FRM_W'(idx_q);

  always_comb begin
    if (cmd_q == CMD_FREE) begin
      cnt_new = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
    end else begin
      cnt_new = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
    end
  end

  assign push   = cmd.update && (cmd_q == CMD_FREE) && (cnt_new == '0) && !stk_full;
  assign stk_re = cmd.issue && is_alloc;
  assign cnt_re = (cmd.issue && !is_alloc) || cmd.stk;
  assign cnt_ra = cmd.stk ? stk_q : idx_q;
  assign cnt_we = cmd.clear || cmd.update;
  assign cnt_wa = cmd.clear ? clr_addr : idx_q;
  assign cnt_wd = cmd.clear ? '0 : cnt_new;

  assign sts.clear_last = (clr_addr == IDX_W'(NUM_PAGES - 1));
  assign sts.early      = early_q;
  assign sts.is_alloc   = is_alloc;

  // Memories
  always_ff @(posedge clk) begin
    if (push) stk_mem[depth[IDX_W-1:0]] <= idx_q;
    if (stk_re) stk_q <= stk_mem[IDX_W'(depth - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= REGION_START_RST;
      region_end   <= REGION_END_RST;
      depth        <= '0;
      clr_addr     <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_REGION_START: region_start <= cfg_data;
          REG_REGION_END:   region_end   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (stk_re) begin
        depth <= depth - 1'b1;
      end else if (push) begin
        depth <= depth + 1'b1;
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= command;
      addr_q <= page_addr;
    end
    if (cmd.check) begin
      idx_q     <= rel[IDX_W-1:0];
      res_addr  <= '0;
      res_count <= '0;
      case (cmd_q)
        CMD_ALLOC: begin
          early_q    <= (depth == '0);
          res_status <= ST_EMPTY;
        end
        CMD_ADD, CMD_FREE: begin
          early_q    <= !addr_ok;
          res_status <= ST_BAD;
        end
        default: begin
          early_q    <= 1'b1;
          res_status <= ST_BAD;
        end
      endcase
    end else if (cmd.stk) begin
      idx_q <= stk_q;
    end else if (cmd.update) begin
      res_count <= REF_W'(cnt_new);
      case (cmd_q)
        CMD_ALLOC: begin
          res_addr   <= {frame_sum, {PG_SH{1'b0}}};
          res_status <= ST_ALLOC;
        end
        CMD_ADD: res_status <= ST_ADDED;
        default: begin
          if (cnt_new != '0) begin
            res_status <= ST_HELD;
          end else if (stk_full) begin
            res_status <= ST_OVER;
          end else begin
            res_status <= ST_FREED;
          end
        end
      endcase
    end
    if (cmd.load_out) begin
      result_addr <= res_addr;
      ref_count   <= res_count;
      status      <= res_status;
    end
  end

endmodule
`default_nettype wire

/* tb/refcounted_page_allocator_tb.sv */
// Self-checking testbench for the reference-counted page allocator: directed table, then random
// commands over several regions, checked against fixed expectations or a behavioral predictor.
module refcounted_page_allocator_tb;
  import rpa_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES_DEF);
  localparam int NUM_FRAMES = NUM_PAGES_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_REGIONS = 6;
  localparam int RANDOM_PER_REGION = 160;
  localparam int RANDOM_EMPTY_REGION = 40;
  localparam int SETTLE_CYCLES = 8;

  // region settings: default, bottom of address space, top of address space, unaligned and
  // short, wider than the frame count, empty
  localparam logic [ADDR_W-1:0] SPAN_LO [N_REGIONS] = '{
    56'h8000_0000, 56'h0, 56'hFF_FFFF_FC00_0000, 56'h1234_5678, 56'h1_0000_0000,
    56'hFF_FFFF_FFFF_FFFF};
  localparam logic [ADDR_W-1:0] SPAN_HI [N_REGIONS] = '{
    56'h8400_0000, 56'h400_0000, 56'hFF_FFFF_FFFF_FFFF, 56'h123A_9678, 56'hFF_FFFF_FFFF_FFFF,
    56'h0};

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [REF_W-1:0]  cnt;
    logic [STS_W-1:0]  sts;
  } page_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    page_result_t      want;
  } probe_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command = '0;
  logic [ADDR_W-1:0] page_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] result_addr;
  logic [REF_W-1:0]  ref_count;
  logic [STS_W-1:0]  status;

  // predictor state
  logic [ADDR_W-1:0] region_lo = REGION_START_RST;
  logic [ADDR_W-1:0] region_hi = REGION_END_RST;
  logic [REF_W-1:0]  ref_table [NUM_FRAMES];
  int unsigned       frame_stack [NUM_FRAMES];
  int unsigned       stack_fill = 0;

  page_result_t awaited [$];
  int mismatch_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  // default region: frame 0 at 0x8000_0000, last frame at 0x83FF_F000
  probe_t probes [20] = '{
    '{CMD_ALLOC,  56'h0,                 1'b1, '{56'h0,         16'd0, ST_EMPTY}},
    '{CMD_ADD,    56'h8000_0001,         1'b1, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_FREE,   56'h7FFF_F000,         1'b1, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_FREE,   56'h8400_0000,         1'b1, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_ADD,    56'hFF_FFFF_FFFF_F000, 1'b1, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_UNUSED, 56'h8000_0000,         1'b1, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_ADD,    56'h0,                 1'b1, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_ADD,    56'h8000_0000,         1'b1, '{56'h0,         16'd1, ST_ADDED}},
    '{CMD_ADD,    56'h83FF_F000,         1'b1, '{56'h0,         16'd1, ST_ADDED}},
    '{CMD_FREE,   56'h8000_0000,         1'b1, '{56'h0,         16'd0, ST_FREED}},
    '{CMD_FREE,   56'h8000_0000,         1'b1, '{56'h0,         16'd0, ST_FREED}},
    '{CMD_ALLOC,  56'h0,                 1'b1, '{56'h8000_0000, 16'd1, ST_ALLOC}},
    '{CMD_ALLOC,  56'hFF_FFFF_FFFF_FFFF, 1'b1, '{56'h8000_0000, 16'd2, ST_ALLOC}},
    '{CMD_FREE,   56'h8000_0000,         1'b1, '{56'h0,         16'd1, ST_HELD}},
    '{CMD_ADD,    56'h83FF_F000,         1'b0, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_FREE,   56'h83FF_F000,         1'b0, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_FREE,   56'h83FF_F000,         1'b0, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_ALLOC,  56'h0,                 1'b0, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_ALLOC,  56'h0,                 1'b0, '{56'h0,         16'd0, ST_BAD}},
    '{CMD_UNUSED, 56'hFF_FFFF_FFFF_FFFF, 1'b1, '{56'h0,         16'd0, ST_BAD}}
  };

  always #2 clk = ~clk;

  refcounted_page_allocator uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .page_addr(page_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_addr(result_addr),
    .ref_count(ref_count),
    .status(status)
  );

  function automatic bit frame_index(input logic [ADDR_W-1:0] a, output int unsigned idx);
    logic [63:0] rel;
    idx = 0;
    if (a[PAGE_SHIFT-1:0] != '0) return 1'b0;
    if (a < region_lo || a >= region_hi) return 1'b0;
    rel = 64'(a >> PAGE_SHIFT) - 64'(region_lo >> PAGE_SHIFT);
    if (rel >= 64'(NUM_FRAMES)) return 1'b0;
    idx = rel[31:0];
    return 1'b1;
  endfunction

  function automatic logic [REF_W-1:0] bump(input logic [REF_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic page_result_t model_command(input logic [CMD_W-1:0] c,
                                                 input logic [ADDR_W-1:0] a);
    page_result_t r;
    int unsigned idx;
    logic [63:0] page;
    r = '0;
    r.sts = ST_BAD;
    case (c)
      CMD_ALLOC: begin
        if (stack_fill == 0) begin
          r.sts = ST_EMPTY;
        end else begin
          stack_fill--;
          idx = frame_stack[stack_fill];
          ref_table[idx] = bump(ref_table[idx]);
          r.cnt = ref_table[idx];
          // address follows the region in force now, not the one at free time
          page = (64'(region_lo >> PAGE_SHIFT) + 64'(idx)) << PAGE_SHIFT;
          r.addr = page[ADDR_W-1:0];
          r.sts = ST_ALLOC;
        end
      end
      CMD_ADD: begin
        if (frame_index(a, idx)) begin
          ref_table[idx] = bump(ref_table[idx]);
          r.cnt = ref_table[idx];
          r.sts = ST_ADDED;
        end
      end
      CMD_FREE: begin
        if (frame_index(a, idx)) begin
          if (ref_table[idx] != '0) ref_table[idx] = ref_table[idx] - 1'b1;
          r.cnt = ref_table[idx];
          if (r.cnt != '0) begin
            r.sts = ST_HELD;
          end else if (stack_fill >= NUM_FRAMES) begin
            r.sts = ST_OVER;
          end else begin
            frame_stack[stack_fill] = idx;
            stack_fill++;
            r.sts = ST_FREED;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 28) return CMD_ALLOC;
    if (r < 58) return CMD_ADD;
    if (r < 95) return CMD_FREE;
    return CMD_UNUSED;
  endfunction

  // Mostly frames near both ends of the valid window so counts rise and fall; some misaligned,
  // just outside, and fully random addresses.
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [63:0] lo_f, hi_f, cap_f, span, w, f, page;
    int unsigned r;
    r = $urandom_range(99);
    page = {$urandom, $urandom};
    lo_f = (64'(region_lo) + 64'(PAGE_BYTES_DEF - 1)) >> PAGE_SHIFT;
    cap_f = 64'(region_lo >> PAGE_SHIFT) + 64'(NUM_FRAMES - 1);
    hi_f = (64'(region_hi) - 64'd1) >> PAGE_SHIFT;
    if (cap_f < hi_f) hi_f = cap_f;
    if (region_hi == '0 || lo_f > hi_f || r >= 96) return page[ADDR_W-1:0];
    span = hi_f - lo_f;
    w = (span < 64'd15) ? span : 64'd15;
    if (r < 40) begin
      f = lo_f + 64'($urandom_range(w[31:0]));
    end else if (r < 70) begin
      f = hi_f - 64'($urandom_range(w[31:0]));
    end else if (r < 80) begin
      f = lo_f + ({$urandom, $urandom} % (span + 64'd1));
    end else if (r < 88) begin
      f = lo_f + 64'($urandom_range(w[31:0]));
      page = (f << PAGE_SHIFT) | 64'($urandom_range(PAGE_BYTES_DEF - 1, 1));
      return page[ADDR_W-1:0];
    end else begin
      f = r[0] ? lo_f - 64'd1 : hi_f + 64'd1;
    end
    page = f << PAGE_SHIFT;
    return page[ADDR_W-1:0];
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                           input bit typed, input page_result_t want);
    page_result_t guess;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command <= c;
    page_addr <= a;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = model_command(c, a);
    awaited.push_back(typed ? want : guess);
  endtask

  // every item gives exactly one result; wait until all of them have been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_REGION_END;
    cfg_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    region_lo = lo;
    region_hi = hi;
  endtask

  always @(posedge clk) begin : result_check
    page_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("unexpected item: result_addr %h ref_count %0d status %0d",
               result_addr, ref_count, status);
        mismatch_count++;
      end else begin
        want = awaited.pop_front();
        if (result_addr !== want.addr) begin
          $error("result_addr: expected %h, got %h", want.addr, result_addr);
          mismatch_count++;
        end
        if (ref_count !== want.cnt) begin
          $error("ref_count: expected %0d, got %0d", want.cnt, ref_count);
          mismatch_count++;
        end
        if (status !== want.sts) begin
          $error("status: expected %0d, got %0d", want.sts, status);
          mismatch_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    for (int i = 0; i < NUM_FRAMES; i++) ref_table[i] = '0;
    send_gap_pct = 14;
    stall_pct = 73;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) send_item(probes[i].cmd, probes[i].addr, probes[i].typed, probes[i].want);

    for (int k = 0; k < N_REGIONS; k++) begin
      settle();
      set_region(SPAN_LO[k], SPAN_HI[k]);
      if (k == 2) begin
        send_gap_pct = 73;
        stall_pct = 14;
      end else if (k == 4) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      repeat (k == N_REGIONS - 1 ? RANDOM_EMPTY_REGION : RANDOM_PER_REGION)
        send_item(pick_command(), pick_addr(), 1'b0, '0);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
